// File: hw/rtl/oat_pkg.sv
package oat_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int REQ_W    = 3;
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 48;
    localparam int TAG_W    = 32;
    localparam int RD_IDX_W = 6;
    localparam int STAT_W   = 2;

    // One table entry as it travels along the chain.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  file;
        logic [TAG_W-1:0]  func;
        logic [TAG_W-1:0]  line;
    } entry_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_TRACK  = 3'd0,
        REQ_MODIFY = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_READ   = 3'd4
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FILL
    } fsm_t;

    // Control handed from the controller to the chain of cells.
    typedef struct packed {
        logic   shift;
        entry_t tail;
    } chain_ctl_t;

endpackage

// File: hw/rtl/oat_cell.sv
module oat_cell
(
    input  logic           clk,
    input  logic           shift,
    input  oat_pkg::entry_t d_in,
    output oat_pkg::entry_t q
);

    oat_pkg::entry_t entry_reg;
    oat_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// File: hw/rtl/oat_ctrl.sv
module oat_ctrl #(
    parameter int TABLE_DEPTH = oat_pkg::DEPTH_DEF,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [oat_pkg::REQ_W-1:0]     req_type,
    input  logic [oat_pkg::ADDR_W-1:0]    addr,
    input  logic [oat_pkg::ADDR_W-1:0]    new_addr,
    input  logic [oat_pkg::SIZE_W-1:0]    alloc_size,
    input  logic [oat_pkg::TAG_W-1:0]     file_tag,
    input  logic [oat_pkg::TAG_W-1:0]     func_tag,
    input  logic [oat_pkg::TAG_W-1:0]     line_no,
    input  logic [oat_pkg::RD_IDX_W-1:0]  read_index,
    input  oat_pkg::entry_t               head,
    output oat_pkg::chain_ctl_t           chain_ctl,
    output logic                          done,
    output logic [oat_pkg::STAT_W-1:0]    status,
    output logic [CNT_W-1:0]              entry_count,
    output oat_pkg::entry_t               rd_entry
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int RW    = (CNT_W > oat_pkg::RD_IDX_W) ? CNT_W : oat_pkg::RD_IDX_W;

    oat_pkg::fsm_t                  state_reg;
    oat_pkg::fsm_t                  state_next;
    logic [IDX_W-1:0]               step_reg;
    logic [CNT_W-1:0]               count_reg;
    logic                           found_reg;
    logic                           done_reg;
    logic [oat_pkg::STAT_W-1:0]     status_reg;

    logic [oat_pkg::REQ_W-1:0]      req_reg;
    logic [oat_pkg::ADDR_W-1:0]     key_reg;
    oat_pkg::entry_t                new_reg;
    logic [oat_pkg::RD_IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]               hit_reg;
    oat_pkg::entry_t                last_reg;
    oat_pkg::entry_t                rd_reg;

    logic                           accept;
    logic [CNT_W-1:0]               step_c;
    logic                           in_range;
    logic                           match;
    logic                           found_now;
    logic                           last_step;
    logic                           read_ok;
    logic                           read_here;
    oat_pkg::entry_t                feedback;

    assign accept    = start && (state_reg == oat_pkg::FSM_IDLE);
    assign step_c    = CNT_W'(step_reg);
    assign in_range  = step_c < count_reg;
    assign match     = in_range && (head.addr == key_reg);
    assign found_now = found_reg || match;
    assign last_step = step_reg == IDX_W'(TABLE_DEPTH - 1);
    assign read_ok   = RW'(idx_reg) < RW'(count_reg);
    assign read_here = read_ok && (RW'(idx_reg) == RW'(step_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oat_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        oat_pkg::REQ_TRACK,
                        oat_pkg::REQ_MODIFY,
                        oat_pkg::REQ_REMOVE,
                        oat_pkg::REQ_READ:
                            state_next = oat_pkg::FSM_SCAN;
                        default:
                            state_next = oat_pkg::FSM_IDLE;
                    endcase
                end
            end
            oat_pkg::FSM_SCAN:
            begin
                if (last_step)
                begin
                    if ((req_reg == oat_pkg::REQ_REMOVE) && found_now)
                    begin
                        state_next = oat_pkg::FSM_FILL;
                    end
                    else
                    begin
                        state_next = oat_pkg::FSM_IDLE;
                    end
                end
            end
            oat_pkg::FSM_FILL:
            begin
                if (last_step)
                begin
                    state_next = oat_pkg::FSM_IDLE;
                end
            end
            default:
                state_next = oat_pkg::FSM_IDLE;
        endcase
    end

    // Outputs: the entry fed back into the tail of the ring, busy and the shift enable.
    always_comb
    begin
        feedback = head;
        case (state_reg)
            oat_pkg::FSM_SCAN:
            begin
                case (req_reg)
                    oat_pkg::REQ_TRACK:
                    begin
                        // The free slot sits at the position equal to the count.
                        if (step_c == count_reg)
                        begin
                            feedback = new_reg;
                        end
                    end
                    oat_pkg::REQ_MODIFY:
                    begin
                        if (match && !found_reg)
                        begin
                            feedback = new_reg;
                        end
                    end
                    default:
                        feedback = head;
                endcase
            end
            oat_pkg::FSM_FILL:
            begin
                // Second lap of a remove: the last entry fills the hole.
                if (step_reg == hit_reg)
                begin
                    feedback = last_reg;
                end
            end
            default:
                feedback = head;
        endcase
        busy            = state_reg != oat_pkg::FSM_IDLE;
        chain_ctl.shift = (state_reg == oat_pkg::FSM_SCAN) || (state_reg == oat_pkg::FSM_FILL);
        chain_ctl.tail  = feedback;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= oat_pkg::FSM_IDLE;
            step_reg   <= '0;
            count_reg  <= '0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= oat_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                oat_pkg::FSM_IDLE:
                begin
                    if (accept)
                    begin
                        step_reg  <= '0;
                        found_reg <= 1'b0;
                        case (req_type)
                            oat_pkg::REQ_TRACK,
                            oat_pkg::REQ_MODIFY,
                            oat_pkg::REQ_REMOVE,
                            oat_pkg::REQ_READ:
                                done_reg <= 1'b0;
                            oat_pkg::REQ_CLEAR:
                            begin
                                count_reg  <= '0;
                                status_reg <= oat_pkg::ST_OK;
                                done_reg   <= 1'b1;
                            end
                            default:
                            begin
                                status_reg <= oat_pkg::ST_OK;
                                done_reg   <= 1'b1;
                            end
                        endcase
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                oat_pkg::FSM_SCAN:
                begin
                    // The step wraps at the end of a lap so the ring stays aligned.
                    step_reg <= last_step ? '0 : step_reg + 1'b1;
                    if (match)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (last_step)
                    begin
                        case (req_reg)
                            oat_pkg::REQ_TRACK:
                            begin
                                done_reg <= 1'b1;
                                if (count_reg == CNT_W'(TABLE_DEPTH))
                                begin
                                    status_reg <= oat_pkg::ST_FULL;
                                end
                                else
                                begin
                                    status_reg <= oat_pkg::ST_OK;
                                    count_reg  <= count_reg + 1'b1;
                                end
                            end
                            oat_pkg::REQ_MODIFY:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= found_now ? oat_pkg::ST_OK : oat_pkg::ST_NOT_FOUND;
                            end
                            oat_pkg::REQ_REMOVE:
                            begin
                                if (!found_now)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= oat_pkg::ST_NOT_FOUND;
                                end
                                else
                                begin
                                    done_reg <= 1'b0;
                                end
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= read_ok ? oat_pkg::ST_OK : oat_pkg::ST_BAD_INDEX;
                            end
                        endcase
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                oat_pkg::FSM_FILL:
                begin
                    step_reg <= last_step ? '0 : step_reg + 1'b1;
                    if (last_step)
                    begin
                        count_reg  <= count_reg - 1'b1;
                        status_reg <= oat_pkg::ST_OK;
                        done_reg   <= 1'b1;
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                default:
                    done_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg       <= req_type;
            key_reg       <= addr;
            new_reg.addr  <= (req_type == oat_pkg::REQ_MODIFY) ? new_addr : addr;
            new_reg.size  <= alloc_size;
            new_reg.file  <= file_tag;
            new_reg.func  <= func_tag;
            new_reg.line  <= line_no;
            idx_reg       <= read_index;
            rd_reg        <= '0;
        end
        else if (state_reg == oat_pkg::FSM_SCAN)
        begin
            if (match && !found_reg)
            begin
                hit_reg <= step_reg;
            end
            if (step_c == count_reg - 1'b1)
            begin
                last_reg <= head;
            end
            if ((req_reg == oat_pkg::REQ_READ) && read_here)
            begin
                rd_reg <= head;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign rd_entry    = rd_reg;

endmodule

// File: hw/rtl/outstanding_alloc_table_unit.sv
// Table of outstanding allocations held in a ring of TABLE_DEPTH cells that
// rotates one position per cycle while busy, so the controller sees every
// entry at the head of the ring once per lap. A transaction is taken when
// start is high and busy is low. Track, modify, read and a remove of a
// missing address take one lap: the result strobe done rises at the end of
// that lap. A remove that finds its address takes a second lap to move the
// last entry into the hole and raises done at its end. Clear and unknown
// request types answer on the next cycle. The result is shown for exactly one
// cycle while done is high and is not held, so the receiver must capture it
// then. The out_* fields are zero except on a successful read.
module outstanding_alloc_table_unit #(
    parameter int TABLE_DEPTH = oat_pkg::DEPTH_DEF,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [oat_pkg::REQ_W-1:0]     req_type,
    input  logic [oat_pkg::ADDR_W-1:0]    addr,
    input  logic [oat_pkg::ADDR_W-1:0]    new_addr,
    input  logic [oat_pkg::SIZE_W-1:0]    alloc_size,
    input  logic [oat_pkg::TAG_W-1:0]     file_tag,
    input  logic [oat_pkg::TAG_W-1:0]     func_tag,
    input  logic [oat_pkg::TAG_W-1:0]     line_no,
    input  logic [oat_pkg::RD_IDX_W-1:0]  read_index,
    output logic                          done,
    output logic [oat_pkg::STAT_W-1:0]    status,
    output logic [CNT_W-1:0]              entry_count,
    output logic [oat_pkg::ADDR_W-1:0]    out_addr,
    output logic [oat_pkg::SIZE_W-1:0]    out_size,
    output logic [oat_pkg::TAG_W-1:0]     out_file_tag,
    output logic [oat_pkg::TAG_W-1:0]     out_func_tag,
    output logic [oat_pkg::TAG_W-1:0]     out_line
);

    oat_pkg::entry_t     cell_q [TABLE_DEPTH];
    oat_pkg::chain_ctl_t chain_ctl;
    oat_pkg::entry_t     rd_entry;

    oat_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .addr        (addr),
        .new_addr    (new_addr),
        .alloc_size  (alloc_size),
        .file_tag    (file_tag),
        .func_tag    (func_tag),
        .line_no     (line_no),
        .read_index  (read_index),
        .head        (cell_q[0]),
        .chain_ctl   (chain_ctl),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .rd_entry    (rd_entry)
    );

    // Each cell takes its upper neighbor's entry; the top cell takes the
    // entry the controller feeds back from the head.
    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++)
        begin : g_cell
            if (k == TABLE_DEPTH - 1)
            begin : g_tail
                oat_cell u_cell (
                    .clk   (clk),
                    .shift (chain_ctl.shift),
                    .d_in  (chain_ctl.tail),
                    .q     (cell_q[k])
                );
            end
            else
            begin : g_body
                oat_cell u_cell (
                    .clk   (clk),
                    .shift (chain_ctl.shift),
                    .d_in  (cell_q[k+1]),
                    .q     (cell_q[k])
                );
            end
        end
    endgenerate

    assign out_addr     = rd_entry.addr;
    assign out_size     = rd_entry.size;
    assign out_file_tag = rd_entry.file;
    assign out_func_tag = rd_entry.func;
    assign out_line     = rd_entry.line;

endmodule

// File: dv/tb_outstanding_alloc_table_unit.sv
`timescale 1ns / 100ps

module tb_outstanding_alloc_table_unit;

    import oat_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Request codes the block does not define; it answers them with ok.
    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   new_addr;
        logic [SIZE_W-1:0]   size;
        logic [TAG_W-1:0]    file;
        logic [TAG_W-1:0]    func;
        logic [TAG_W-1:0]    line;
        logic [RD_IDX_W-1:0] index;
    } alloc_req_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] count;
        entry_t           ent;
    } alloc_answer_t;

    typedef struct {
        alloc_req_t    req;
        bit            literal;
        alloc_answer_t answer;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [REQ_W-1:0]      req_type;
    logic [ADDR_W-1:0]     addr;
    logic [ADDR_W-1:0]     new_addr;
    logic [SIZE_W-1:0]     alloc_size;
    logic [TAG_W-1:0]      file_tag;
    logic [TAG_W-1:0]      func_tag;
    logic [TAG_W-1:0]      line_no;
    logic [RD_IDX_W-1:0]   read_index;
    logic                  done;
    logic [STAT_W-1:0]     status;
    logic [CNT_W-1:0]      entry_count;
    logic [ADDR_W-1:0]     out_addr;
    logic [SIZE_W-1:0]     out_size;
    logic [TAG_W-1:0]      out_file_tag;
    logic [TAG_W-1:0]      out_func_tag;
    logic [TAG_W-1:0]      out_line;

    // Predicted contents of the table.
    entry_t          alloc_slots [DEPTH];
    int              alloc_count;
    alloc_answer_t   pending_answers [$];
    directed_row_t   directed_rows [$];
    int              mismatches;

    outstanding_alloc_table_unit #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .addr         (addr),
        .new_addr     (new_addr),
        .alloc_size   (alloc_size),
        .file_tag     (file_tag),
        .func_tag     (func_tag),
        .line_no      (line_no),
        .read_index   (read_index),
        .done         (done),
        .status       (status),
        .entry_count  (entry_count),
        .out_addr     (out_addr),
        .out_size     (out_size),
        .out_file_tag (out_file_tag),
        .out_func_tag (out_func_tag),
        .out_line     (out_line)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int find_first(input logic [ADDR_W-1:0] key);
        for (int i = 0; i < alloc_count; i++)
        begin
            if (alloc_slots[i].addr == key)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the predicted table and returns its answer.
    function automatic alloc_answer_t predict_answer(input alloc_req_t rq);
        alloc_answer_t ans;
        int            hit;
        ans = '0;
        ans.status = ST_OK;
        case (rq.kind)
            REQ_TRACK:
            begin
                if (alloc_count >= DEPTH)
                    ans.status = ST_FULL;
                else
                begin
                    alloc_slots[alloc_count] = '{rq.addr, rq.size, rq.file, rq.func, rq.line};
                    alloc_count++;
                end
            end
            REQ_MODIFY:
            begin
                hit = find_first(rq.addr);
                if (hit < 0)
                    ans.status = ST_NOT_FOUND;
                else
                    alloc_slots[hit] = '{rq.new_addr, rq.size, rq.file, rq.func, rq.line};
            end
            REQ_REMOVE:
            begin
                hit = find_first(rq.addr);
                if (hit < 0)
                    ans.status = ST_NOT_FOUND;
                else
                begin
                    alloc_slots[hit] = alloc_slots[alloc_count - 1];
                    alloc_count--;
                end
            end
            REQ_CLEAR:
                alloc_count = 0;
            REQ_READ:
            begin
                if (int'(rq.index) >= alloc_count)
                    ans.status = ST_BAD_INDEX;
                else
                    ans.ent = alloc_slots[rq.index];
            end
            default:
                ;
        endcase
        ans.count = CNT_W'(alloc_count);
        return ans;
    endfunction

    task automatic add_row(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] a,
                           input logic [ADDR_W-1:0] na, input logic [SIZE_W-1:0] sz,
                           input logic [TAG_W-1:0] ft, input logic [TAG_W-1:0] fn,
                           input logic [TAG_W-1:0] ln, input logic [RD_IDX_W-1:0] idx,
                           input bit literal, input status_t st, input int cnt,
                           input entry_t ent);
        directed_row_t row;
        row.req     = '{kind, a, na, sz, ft, fn, ln, idx};
        row.literal = literal;
        row.answer  = '{st, CNT_W'(cnt), ent};
        directed_rows.push_back(row);
    endtask

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // Mostly addresses already in the table, plus a small pool so duplicates
    // occur, plus fully random values.
    function automatic logic [ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(9);
        if (alloc_count > 0 && r < 6)
            return alloc_slots[$urandom_range(alloc_count - 1)].addr;
        if (r < 8)
            return ADDR_W'($urandom_range(15));
        return rand48();
    endfunction

    // mode 0 grows the table, mode 1 shrinks it, mode 2 is balanced.
    function automatic alloc_req_t random_request(input int mode);
        alloc_req_t rq;
        int         r;
        int         track_pct;
        int         remove_pct;
        rq.addr     = pick_addr();
        rq.new_addr = ($urandom_range(1) == 0) ? pick_addr() : rand48();
        rq.size     = ($urandom_range(3) == 0) ? ADDR_W'($urandom_range(4096)) : rand48();
        rq.file     = $urandom;
        rq.func     = $urandom;
        rq.line     = $urandom;
        if (alloc_count > 0 && $urandom_range(3) != 0)
            rq.index = RD_IDX_W'($urandom_range(alloc_count - 1));
        else
            rq.index = RD_IDX_W'($urandom_range(DEPTH - 1));
        track_pct  = (mode == 0) ? 70 : (mode == 1) ? 15 : 35;
        remove_pct = (mode == 0) ? 8 : (mode == 1) ? 45 : 30;
        r = $urandom_range(199);
        if (r == 0)
            rq.kind = REQ_CLEAR;
        else if (r == 1)
            rq.kind = REQ_RSVD5;
        else if (r == 2)
            rq.kind = ($urandom_range(1) == 0) ? REQ_RSVD6 : REQ_RSVD7;
        else
        begin
            r = $urandom_range(99);
            if (r < track_pct)
                rq.kind = REQ_TRACK;
            else if (r < track_pct + remove_pct)
                rq.kind = REQ_REMOVE;
            else if (r < track_pct + remove_pct + 12)
                rq.kind = REQ_MODIFY;
            else
                rq.kind = REQ_READ;
        end
        return rq;
    endfunction

    // Waits out the gap, holds start until the transaction is taken and busy is
    // low again, then queues the answer it should produce.
    task automatic send_request(input alloc_req_t rq, input bit literal,
                                input alloc_answer_t literal_answer, input int gap);
        alloc_answer_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= rq.kind;
        addr       <= rq.addr;
        new_addr   <= rq.new_addr;
        alloc_size <= rq.size;
        file_tag   <= rq.file;
        func_tag   <= rq.func;
        line_no    <= rq.line;
        read_index <= rq.index;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_answer(rq);
        pending_answers.push_back(literal ? literal_answer : predicted);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        alloc_answer_t exp_a;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result with no transaction outstanding", $time);
                mismatches++;
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                check_field("status", exp_a.status, status);
                check_field("entry_count", exp_a.count, entry_count);
                check_field("out_addr", exp_a.ent.addr, out_addr);
                check_field("out_size", exp_a.ent.size, out_size);
                check_field("out_file_tag", exp_a.ent.file, out_file_tag);
                check_field("out_func_tag", exp_a.ent.func, out_func_tag);
                check_field("out_line", exp_a.ent.line, out_line);
            end
        end
    end

    initial
    begin
        alloc_req_t rq;
        int         mode;
        int         quiet;
        int         gap;
        mismatches  = 0;
        alloc_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_CLEAR;
        addr        = '0;
        new_addr    = '0;
        alloc_size  = '0;
        file_tag    = '0;
        func_tag    = '0;
        line_no     = '0;
        read_index  = '0;

        // Empty table, extremes of every field, first-match and swap-remove
        // behavior, missing addresses, undefined codes and clear.
        add_row(REQ_READ, '0, '0, '0, '0, '0, '0, 0, 1, ST_BAD_INDEX, 0, '0);
        add_row(REQ_REMOVE, '0, '0, '0, '0, '0, '0, 0, 1, ST_NOT_FOUND, 0, '0);
        add_row(REQ_MODIFY, '1, '1, '1, '1, '1, '1, '1, 1, ST_NOT_FOUND, 0, '0);
        add_row(REQ_TRACK, '1, '0, '1, '1, '1, '1, 0, 1, ST_OK, 1, '0);
        add_row(REQ_TRACK, '0, '1, '0, '0, '0, '0, '1, 1, ST_OK, 2, '0);
        add_row(REQ_READ, '0, '0, '0, '0, '0, '0, 0, 1, ST_OK, 2, '1);
        add_row(REQ_READ, '1, '1, '1, '1, '1, '1, 1, 1, ST_OK, 2, '0);
        add_row(REQ_READ, '0, '0, '0, '0, '0, '0, 2, 1, ST_BAD_INDEX, 2, '0);
        add_row(REQ_READ, '0, '0, '0, '0, '0, '0, '1, 1, ST_BAD_INDEX, 2, '0);
        add_row(REQ_MODIFY, '1, 48'h5555_AAAA_0F0F, 48'hA5A5_5A5A_C3C3, 32'h1234_5678,
                32'h9ABC_DEF0, 32'd77, 0, 0, ST_OK, 0, '0);
        add_row(REQ_TRACK, '0, '0, 48'h1000, 32'hCAFE_0001, 32'hCAFE_0002, 32'd100, 0,
                0, ST_OK, 0, '0);
        add_row(REQ_MODIFY, '0, 48'h77, 48'h2000, 32'h3, 32'h4, 32'd5, 0, 0, ST_OK, 0, '0);
        add_row(REQ_READ, '0, '0, '0, '0, '0, '0, 1, 0, ST_OK, 0, '0);
        add_row(REQ_REMOVE, 48'h5555_AAAA_0F0F, '0, '0, '0, '0, '0, 0, 0, ST_OK, 0, '0);
        add_row(REQ_READ, '0, '0, '0, '0, '0, '0, 0, 0, ST_OK, 0, '0);
        add_row(REQ_REMOVE, 48'hDEAD, '0, '0, '0, '0, '0, 0, 1, ST_NOT_FOUND, 2, '0);
        add_row(REQ_RSVD5, '1, '1, '1, '1, '1, '1, '1, 1, ST_OK, 2, '0);
        add_row(REQ_RSVD6, '0, '0, '0, '0, '0, '0, 0, 1, ST_OK, 2, '0);
        add_row(REQ_RSVD7, '1, '1, '1, '1, '1, '1, 0, 1, ST_OK, 2, '0);
        // Removing the last entry moves nothing.
        add_row(REQ_REMOVE, 48'h77, '0, '0, '0, '0, '0, 0, 0, ST_OK, 0, '0);
        add_row(REQ_CLEAR, '1, '1, '1, '1, '1, '1, '1, 1, ST_OK, 0, '0);
        add_row(REQ_READ, '0, '0, '0, '0, '0, '0, 0, 1, ST_BAD_INDEX, 0, '0);
        add_row(REQ_TRACK, 48'h1, '0, 48'h40, 32'h1, 32'h2, 32'h3, 0, 1, ST_OK, 1, '0);
        add_row(REQ_REMOVE, 48'h1, '0, '0, '0, '0, '0, 0, 1, ST_OK, 0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].literal,
                         directed_rows[i].answer, $urandom_range(5));
        wait_drained();

        // The first block grows the table until it reports full.
        mode  = 0;
        quiet = 0;
        for (int n = 0; n < 1480; n++)
        begin
            if (n > 0 && n % 150 == 0)
                mode = $urandom_range(2);
            if (n % 40 == 0)
                quiet = ($urandom_range(3) == 0);
            if (n > 0 && n % 300 == 0)
                wait_drained();
            gap = quiet ? 0 : $urandom_range(5);
            rq  = random_request(mode);
            send_request(rq, 1'b0, '0, gap);
        end
        wait_drained();
        repeat (2 * DEPTH + 8) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/oat_pkg.sv
hw/rtl/oat_cell.sv
hw/rtl/oat_ctrl.sv
hw/rtl/outstanding_alloc_table_unit.sv
dv/tb_outstanding_alloc_table_unit.sv
